[hdl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define RBTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also runs during reset
`define RBTU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/rbtu_pkg.sv]
// types and constants of the raster border timing unit
`default_nettype none

package rbtu_pkg;

  localparam int unsigned RegCount = 64;
  localparam int unsigned RegIdxW  = $clog2(RegCount);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  // register offsets
  localparam logic [RegIdxW-1:0] RegCtrlY   = 6'h11;
  localparam logic [RegIdxW-1:0] RegRaster  = 6'h12;
  localparam logic [RegIdxW-1:0] RegCtrlX   = 6'h16;

  // beam timing
  localparam logic [5:0] LastCycle     = 6'd62;
  localparam logic [8:0] LastLine      = 9'd312;
  localparam logic [5:0] FetchCycles   = 6'd40;
  localparam logic [5:0] BadlineCycle  = 6'd5;
  localparam logic [8:0] BadlineFirst  = 9'h030;
  localparam logic [8:0] BadlineLast   = 9'h0f7;
  localparam logic [5:0] VisibleFirst  = 6'd10;
  localparam logic [5:0] VisibleLast   = 6'd59;
  localparam logic [8:0] FirstX        = 9'h194;

  // window edges
  localparam logic [9:0] Left40   = 10'd24;
  localparam logic [9:0] Right40  = 10'd344;
  localparam logic [9:0] Left38   = 10'd31;
  localparam logic [9:0] Right38  = 10'd335;
  localparam logic [8:0] Top25    = 9'd51;
  localparam logic [8:0] Bottom25 = 9'd251;
  localparam logic [8:0] Top24    = 9'd59;   // 51 + 8, less the scroll
  localparam logic [8:0] Bottom24 = 9'd243;  // 251 - 8, plus the scroll

  typedef struct packed {
    logic [1:0]         opcode;
    logic [RegIdxW-1:0] reg_index;
    logic [7:0]         write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [8:0] raster_line;
    logic [5:0] cycle_index;
    logic       visible_cycle;
    logic [7:0] border_mask;
    logic       cpu_stall;
    logic       badline_start;
    logic       frame_end;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/raster_border_timing_unit.sv]
// top level of the raster border timing unit
`default_nettype none

// Raster beam counter, bad line detection and border flip-flops behind a
// 64-byte register window.
//
// channels: one input beat per item (tick, register write or register read)
// on in_valid_i / in_stall_o / in_data_i, one result beat per item on
// out_valid_o / out_stall_i / out_data_o. valid/stall handshake: a beat moves
// on a rising edge with valid high and stall low.
//
// pipeline: an accepted item sits in the input register (where the register
// file has already been read) and is worked on there; its result is then
// registered in the output register. throughput is one item per cycle while
// the receiver does not stall; the eight border pixels of a tick come from one
// chain of eight flag updates in the cycle in which the tick is worked on.
//
// reset: counters at line 0 cycle 0, no fetch running, both border flags set,
// the register file reads as all zero (per-byte valid bits cleared at once).
//
// stall: when the receiver stalls, the output register holds its beat and the
// input register still takes one more beat; after that in_stall_o rises.

`include "assert_macros.svh"

module raster_border_timing_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire rbtu_pkg::in_item_t  in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      rbtu_pkg::out_item_t out_data_o
);

  // handshake and pipeline control
  logic in_accept;
  logic s1_move;
  logic s1_valid_q;
  rbtu_pkg::in_item_t s1_item_q;
  logic out_valid_q;
  rbtu_pkg::out_item_t out_item_q;
  rbtu_pkg::out_item_t out_item_d;

  // register file: one write and one registered read per cycle
  logic [7:0] reg_mem [rbtu_pkg::RegCount];
  logic [rbtu_pkg::RegCount-1:0] reg_vld_q;
  logic [7:0] rd_mem_q;
  logic rd_vld_q;

  // shadow copies of the control bytes used by every tick
  logic [7:0] ctrl_y_q, ctrl_y_d;
  logic [7:0] ctrl_x_q, ctrl_x_d;

  // beam state
  logic [8:0] line_q, line_d;
  logic [5:0] cycle_q, cycle_d;
  logic [5:0] fetch_cnt_q, fetch_cnt_d;
  logic main_flag_q, main_flag_d;
  logic vert_flag_q, vert_flag_d;

  // terms watched by the checks
  logic fetch_start;
  logic stall_and_start;

  // the result register frees up when empty or taken this cycle
  assign s1_move     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !s1_move;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
    if (s1_move) begin
      out_item_q <= out_item_d;
    end
  end

  // writes land at acceptance, so any later read, other than of the raster register, sees them
  always_ff @(posedge clk_i) begin
    if (in_accept && (in_data_i.opcode == rbtu_pkg::OP_WRITE)) begin
      reg_mem[in_data_i.reg_index] <= in_data_i.write_data;
    end
    if (in_accept) begin
      rd_mem_q <= reg_mem[in_data_i.reg_index];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else if (in_accept) begin
      if (in_data_i.opcode == rbtu_pkg::OP_WRITE) begin
        reg_vld_q[in_data_i.reg_index] <= 1'b1;
      end
      rd_vld_q <= reg_vld_q[in_data_i.reg_index];
    end
  end

  // beam and border state moves only when an item is worked on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_y_q    <= '0;
      ctrl_x_q    <= '0;
      line_q      <= '0;
      cycle_q     <= '0;
      fetch_cnt_q <= '0;
      main_flag_q <= 1'b1;
      vert_flag_q <= 1'b1;
    end else if (s1_move) begin
      ctrl_y_q    <= ctrl_y_d;
      ctrl_x_q    <= ctrl_x_d;
      line_q      <= line_d;
      cycle_q     <= cycle_d;
      fetch_cnt_q <= fetch_cnt_d;
      main_flag_q <= main_flag_d;
      vert_flag_q <= vert_flag_d;
    end
  end

  // item processing
  always_comb begin
    logic [2:0] scroll;
    logic rows25;
    logic disp_on;
    logic cols40;
    logic [8:0] edge_top;
    logic [8:0] edge_bot;
    logic [9:0] edge_left;
    logic [9:0] edge_right;
    logic [8:0] x_base;
    logic [9:0] x_pix;
    logic mf;
    logic vf;
    logic [8:0] line_nx;

    scroll     = ctrl_y_q[2:0];
    rows25     = ctrl_y_q[3];
    disp_on    = ctrl_y_q[4];
    cols40     = ctrl_x_q[3];
    edge_top   = rows25 ? rbtu_pkg::Top25 : (rbtu_pkg::Top24 - 9'(scroll));
    edge_bot   = rows25 ? rbtu_pkg::Bottom25 : (rbtu_pkg::Bottom24 + 9'(scroll));
    edge_left  = cols40 ? rbtu_pkg::Left40 : rbtu_pkg::Left38;
    edge_right = cols40 ? rbtu_pkg::Right40 : rbtu_pkg::Right38;
    // x of the first pixel wraps at nine bits
    x_base     = rbtu_pkg::FirstX + {cycle_q, 3'b000};
    x_pix      = '0;
    mf         = main_flag_q;
    vf         = vert_flag_q;
    line_nx    = '0;

    ctrl_y_d    = ctrl_y_q;
    ctrl_x_d    = ctrl_x_q;
    line_d      = line_q;
    cycle_d     = cycle_q;
    fetch_cnt_d = fetch_cnt_q;
    main_flag_d = main_flag_q;
    vert_flag_d = vert_flag_q;

    out_item_d               = '0;
    out_item_d.raster_line   = line_q;
    out_item_d.cycle_index   = cycle_q;

    case (s1_item_q.opcode)
      rbtu_pkg::OP_WRITE: begin
        if (s1_item_q.reg_index == rbtu_pkg::RegCtrlY) begin
          ctrl_y_d = s1_item_q.write_data;
        end
        if (s1_item_q.reg_index == rbtu_pkg::RegCtrlX) begin
          ctrl_x_d = s1_item_q.write_data;
        end
      end
      rbtu_pkg::OP_READ: begin
        if (s1_item_q.reg_index == rbtu_pkg::RegRaster) begin
          out_item_d.read_data = line_q[7:0];
        end else if (rd_vld_q) begin
          out_item_d.read_data = rd_mem_q;
        end
      end
      rbtu_pkg::OP_TICK: begin
        // character fetch countdown
        if (fetch_cnt_q != '0) begin
          fetch_cnt_d          = fetch_cnt_q - 6'd1;
          out_item_d.cpu_stall = 1'b1;
        end else if ((cycle_q == rbtu_pkg::BadlineCycle)
                     && (line_q >= rbtu_pkg::BadlineFirst)
                     && (line_q <= rbtu_pkg::BadlineLast)
                     && (line_q[2:0] == scroll)) begin
          fetch_cnt_d              = rbtu_pkg::FetchCycles;
          out_item_d.badline_start = 1'b1;
        end

        // eight pixels, flags carried from one to the next
        if ((cycle_q >= rbtu_pkg::VisibleFirst) && (cycle_q <= rbtu_pkg::VisibleLast)) begin
          out_item_d.visible_cycle = 1'b1;
          for (int i = 0; i < 8; i++) begin
            x_pix = {1'b0, x_base} + 10'(i);
            if (x_pix == edge_right) begin
              mf = 1'b1;
            end else if ((x_pix == edge_left) && (line_q == edge_bot)) begin
              vf = 1'b1;
            end else if (disp_on && (x_pix == edge_left) && (line_q == edge_top)) begin
              vf = 1'b0;
            end
            if ((x_pix == edge_left) && !vf) begin
              mf = 1'b0;
            end
            out_item_d.border_mask[7-i] = mf || vf;
          end
        end

        // beam advance, vertical edges checked on the new line
        if (cycle_q == rbtu_pkg::LastCycle) begin
          cycle_d = '0;
          if (line_q == rbtu_pkg::LastLine) begin
            line_nx              = '0;
            out_item_d.frame_end = 1'b1;
          end else begin
            line_nx = line_q + 9'd1;
          end
          line_d = line_nx;
          if (line_nx == edge_bot) begin
            vf = 1'b1;
          end else if ((line_nx == edge_top) && disp_on) begin
            vf = 1'b0;
          end
        end else begin
          cycle_d = cycle_q + 6'd1;
        end

        main_flag_d = mf;
        vert_flag_d = vf;
      end
      default: begin
        // unused opcode: no effect
      end
    endcase
  end

  // checks
  assign fetch_start     = s1_move && out_item_d.badline_start;
  assign stall_and_start = out_data_o.cpu_stall && out_data_o.badline_start;

  `RBTU_ASSERT(a_fetch_range, fetch_cnt_q <= rbtu_pkg::FetchCycles, "fetch countdown out of range")
  `RBTU_ASSERT(a_cycle_range, cycle_q <= rbtu_pkg::LastCycle, "cycle counter out of range")
  `RBTU_ASSERT(a_line_range, line_q <= rbtu_pkg::LastLine, "line counter out of range")
  `RBTU_ASSERT(a_start_loads, fetch_start |=> fetch_cnt_q == rbtu_pkg::FetchCycles, "no load")
  `RBTU_ASSERT(a_stall_xor_start, out_valid_o |-> !stall_and_start, "stall with fetch start")

endmodule

`default_nettype wire
